@@ rtl/positional_point_list_defines.svh @@
// Assertion macros shared by the positional point list checker.
// Included by bare file name; the user scope must provide i_clk and i_rst_n.
`ifndef POSITIONAL_POINT_LIST_DEFINES_SVH
`define POSITIONAL_POINT_LIST_DEFINES_SVH

// same-cycle implication
`define PPL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ppl_pkg.sv @@
// Package for the positional point list: function and status codes,
// default sizes and the controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppl_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int CNT_W_DEF      = $clog2(CAPACITY_DEF + 1);
    localparam int FUNC_W         = 4;
    localparam int STAT_W         = 2;

    localparam logic [FUNC_W-1:0] FN_INS_FIRST = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INS_LAST  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FIRST = 4'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_LAST  = 4'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_AT    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_GET       = 4'd6;
    localparam logic [FUNC_W-1:0] FN_REPLACE   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_NEXT      = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // request class after decode
    localparam logic [1:0] CL_ERR  = 2'd0;
    localparam logic [1:0] CL_INS  = 2'd1;
    localparam logic [1:0] CL_DEL  = 2'd2;
    localparam logic [1:0] CL_READ = 2'd3;

    typedef struct packed {
        logic capture;
        logic setup;
        logic rd_at;
        logic cap;
        logic shup;
        logic shdn;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [1:0] cls;
        logic       up_last;
        logic       dn_last;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/ppl_if.sv @@
// Request and response channel interfaces of the positional point list.
// Depends on ppl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ppl_req_if #(
    parameter int CNT_W      = ppl_pkg::CNT_W_DEF,
    parameter int COORD_BITS = ppl_pkg::COORD_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic [ppl_pkg::FUNC_W-1:0]    func;
    logic [CNT_W-1:0]              position;
    logic signed [COORD_BITS-1:0]  item_x;
    logic signed [COORD_BITS-1:0]  item_y;

    modport source (output valid, func, position, item_x, item_y, input ready);
    modport sink   (input valid, func, position, item_x, item_y, output ready);
endinterface

interface ppl_rsp_if #(
    parameter int CNT_W      = ppl_pkg::CNT_W_DEF,
    parameter int COORD_BITS = ppl_pkg::COORD_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  out_x;
    logic signed [COORD_BITS-1:0]  out_y;
    logic [CNT_W-1:0]              count;
    logic [ppl_pkg::STAT_W-1:0]    status;

    modport source (output valid, out_x, out_y, count, status, input ready);
    modport sink   (input valid, out_x, out_y, count, status, output ready);
endinterface

`default_nettype wire

@@ rtl/ppl_ctrl.sv @@
// Sequencing state machine of the positional point list.
// Depends on ppl_pkg; drives the datapath through t_cmd, reads t_sts.
`timescale 1ns / 1ps
`default_nettype none

module ppl_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_req_valid,
    output logic           o_req_ready,
    output logic           o_rsp_valid,
    input  wire            i_rsp_ready,
    output ppl_pkg::t_cmd  o_cmd,
    input  ppl_pkg::t_sts  i_sts
);
    import ppl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CAP  = 3'd3;
    localparam logic [2:0] S_SHUP = 3'd4;
    localparam logic [2:0] S_SHDN = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_rsp_valid, n_rsp_valid;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.setup = 1'b1;
                unique case (i_sts.cls)
                    CL_INS:  n_state = S_SHUP;
                    CL_DEL:  n_state = S_RD;
                    CL_READ: n_state = S_RD;
                    default: n_state = S_FIN;
                endcase
            end
            S_RD: begin
                o_cmd.rd_at = 1'b1;
                n_state     = S_CAP;
            end
            S_CAP: begin
                o_cmd.cap = 1'b1;
                priority if (i_sts.cls == CL_DEL) begin
                    n_state = S_SHDN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SHUP: begin
                o_cmd.shup = 1'b1;
                if (i_sts.up_last) begin
                    n_state = S_FIN;
                end
            end
            S_SHDN: begin
                o_cmd.shdn = 1'b1;
                if (i_sts.dn_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

@@ rtl/ppl_dpath.sv @@
// Datapath of the positional point list: entry memory, count, request
// and response registers, decode and shift addressing. Depends on ppl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppl_dpath #(
    parameter int CAPACITY   = ppl_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = ppl_pkg::COORD_BITS_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  ppl_pkg::t_cmd                      i_cmd,
    output ppl_pkg::t_sts                      o_sts,
    input  wire [ppl_pkg::FUNC_W-1:0]          i_func,
    input  wire [CNT_W-1:0]                    i_position,
    input  wire signed [COORD_BITS-1:0]        i_item_x,
    input  wire signed [COORD_BITS-1:0]        i_item_y,
    output logic signed [COORD_BITS-1:0]       o_out_x,
    output logic signed [COORD_BITS-1:0]       o_out_y,
    output logic [CNT_W-1:0]                   o_count,
    output logic [ppl_pkg::STAT_W-1:0]         o_status
);
    import ppl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW = 2 * COORD_BITS;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [EW-1:0]       mem [CAPACITY];

    logic [FUNC_W-1:0]   r_func;
    logic [CNT_W-1:0]    r_pos;
    logic [EW-1:0]       r_item;
    logic [CNT_W-1:0]    r_held;
    logic [CNT_W-1:0]    r_at;
    logic [CNT_W-1:0]    r_idx;
    logic [AW-1:0]       r_wr_addr;
    logic                r_pend;
    logic [EW-1:0]       r_res;
    logic [STAT_W-1:0]   r_status;
    logic [EW-1:0]       r_rd_data;

    logic [1:0]          cls;
    logic [CNT_W-1:0]    at_calc;
    logic [STAT_W-1:0]   stat_calc;
    logic [CNT_W-1:0]    ins_at;
    logic [CNT_W-1:0]    del_at;
    logic [CNT_W:0]      pos_inc;
    logic [CNT_W:0]      held_ext;
    logic [CNT_W:0]      idx_inc;
    logic [CNT_W-1:0]    idx_dec;
    logic                up_more;
    logic                dn_more;

    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [EW-1:0]       mem_wd;
    logic                mem_re;
    logic [AW-1:0]       mem_ra;

    assign held_ext = {1'b0, r_held};
    assign pos_inc  = {1'b0, r_pos} + 1'b1;
    assign idx_inc  = {1'b0, r_idx} + 1'b1;
    assign idx_dec  = r_idx - 1'b1;
    assign up_more  = (r_idx != r_at);
    assign dn_more  = (idx_inc < held_ext);

    always_comb begin
        priority if (r_func == FN_INS_FIRST) begin
            ins_at = '0;
        end else if (r_func == FN_INS_LAST) begin
            ins_at = r_held;
        end else begin
            ins_at = r_pos;
        end
        priority if (r_func == FN_DEL_FIRST) begin
            del_at = '0;
        end else if (r_func == FN_DEL_LAST) begin
            del_at = r_held - 1'b1;
        end else begin
            del_at = r_pos;
        end
    end

    // request decode against the current count
    always_comb begin
        cls       = CL_ERR;
        at_calc   = '0;
        stat_calc = ST_RANGE;
        unique case (r_func)
            FN_INS_FIRST, FN_INS_LAST, FN_INS_AT: begin
                priority if (ins_at > r_held) begin
                    stat_calc = ST_RANGE;
                end else if (r_held == CAP_C) begin
                    stat_calc = ST_FULL;
                end else begin
                    cls       = CL_INS;
                    at_calc   = ins_at;
                    stat_calc = ST_OK;
                end
            end
            FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_AT: begin
                if (r_held != '0 && del_at < r_held) begin
                    cls       = CL_DEL;
                    at_calc   = del_at;
                    stat_calc = ST_OK;
                end
            end
            FN_GET, FN_REPLACE: begin
                if (r_pos < r_held) begin
                    cls       = CL_READ;
                    at_calc   = r_pos;
                    stat_calc = ST_OK;
                end
            end
            FN_NEXT: begin
                if (pos_inc < held_ext) begin
                    cls       = CL_READ;
                    at_calc   = pos_inc[CNT_W-1:0];
                    stat_calc = ST_OK;
                end
            end
            default: begin
                cls = CL_ERR;
            end
        endcase
    end

    assign o_sts.cls     = cls;
    assign o_sts.up_last = !up_more && !r_pend;
    assign o_sts.dn_last = !dn_more && !r_pend;

    // memory port selection; shifts overlap a read with the previous write
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wr_addr;
        mem_wd = r_rd_data;
        mem_re = 1'b0;
        mem_ra = r_at[AW-1:0];
        if (i_cmd.rd_at) begin
            mem_re = 1'b1;
        end
        if (i_cmd.cap && r_func == FN_REPLACE) begin
            mem_we = 1'b1;
            mem_wa = r_at[AW-1:0];
            mem_wd = r_item;
        end
        if (i_cmd.shup) begin
            if (r_pend) begin
                mem_we = 1'b1;
            end else if (!up_more) begin
                mem_we = 1'b1;
                mem_wa = r_at[AW-1:0];
                mem_wd = r_item;
            end
            if (up_more) begin
                mem_re = 1'b1;
                mem_ra = idx_dec[AW-1:0];
            end
        end
        if (i_cmd.shdn) begin
            if (r_pend) begin
                mem_we = 1'b1;
            end
            if (dn_more) begin
                mem_re = 1'b1;
                mem_ra = idx_inc[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_item <= {i_item_y, i_item_x};
        end
        if (i_cmd.setup) begin
            r_at     <= at_calc;
            r_idx    <= (cls == CL_INS) ? r_held : at_calc;
            r_status <= stat_calc;
            r_res    <= '0;
        end
        if (i_cmd.cap) begin
            r_res <= r_rd_data;
        end
        if (i_cmd.shup && up_more) begin
            r_idx     <= idx_dec;
            r_wr_addr <= r_idx[AW-1:0];
        end
        if (i_cmd.shdn && dn_more) begin
            r_idx     <= idx_inc[CNT_W-1:0];
            r_wr_addr <= r_idx[AW-1:0];
        end
        if (i_cmd.load_out) begin
            o_out_x  <= r_res[COORD_BITS-1:0];
            o_out_y  <= r_res[EW-1:COORD_BITS];
            o_count  <= r_held;
            o_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.shup) begin
                r_pend <= up_more;
                if (!up_more && !r_pend) begin
                    r_held <= r_held + 1'b1;
                end
            end
            if (i_cmd.shdn) begin
                r_pend <= dn_more;
                if (!dn_more && !r_pend) begin
                    r_held <= r_held - 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/positional_point_list.sv @@
// Top level of the positional point list: controller plus datapath.
// Depends on ppl_pkg, ppl_if, ppl_ctrl and ppl_dpath.
//
//   channel  | dir | payload                          | handshake
//   i_req    | in  | func, position, item_x, item_y   | valid/ready
//   o_rsp    | out | out_x, out_y, count, status      | valid/ready
//
// One request at a time. Insert and delete shift the entries between the
// position and the end of the list: the shift moves one entry per cycle,
// with one read and one write per cycle on the entry memory.
// Reset clears the count only; entries are undefined until written.
// The response sits in its register until taken; the next request is
// accepted meanwhile and its result waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module positional_point_list #(
    parameter int CAPACITY   = ppl_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = ppl_pkg::COORD_BITS_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    ppl_req_if.sink  i_req,
    ppl_rsp_if.source o_rsp
);
    import ppl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_cmd cmd;
    t_sts sts;

    ppl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    ppl_dpath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .CNT_W      (CNT_W)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_func     (i_req.func),
        .i_position (i_req.position),
        .i_item_x   (i_req.item_x),
        .i_item_y   (i_req.item_y),
        .o_out_x    (o_rsp.out_x),
        .o_out_y    (o_rsp.out_y),
        .o_count    (o_rsp.count),
        .o_status   (o_rsp.status)
    );

endmodule

`default_nettype wire

@@ rtl/ppl_checker.sv @@
// Port-level checks for the positional point list, bound to the top level.
// Depends on ppl_pkg and positional_point_list_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "positional_point_list_defines.svh"

module ppl_checker #(
    parameter int CAPACITY   = ppl_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = ppl_pkg::COORD_BITS_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_req_valid,
    input wire                           i_req_ready,
    input wire                           i_rsp_valid,
    input wire                           i_rsp_ready,
    input wire [COORD_BITS-1:0]          i_rsp_x,
    input wire [COORD_BITS-1:0]          i_rsp_y,
    input wire [CNT_W-1:0]               i_rsp_count,
    input wire [ppl_pkg::STAT_W-1:0]     i_rsp_status
);
    import ppl_pkg::*;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic                                  req_acc;
    logic                                  rsp_stall;
    logic                                  rsp_err;
    logic                                  rsp_full;
    logic [2*COORD_BITS+CNT_W+STAT_W-1:0]  rsp_bus;

    assign req_acc   = i_req_valid && i_req_ready;
    assign rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign rsp_err   = i_rsp_valid && (i_rsp_status != ST_OK);
    assign rsp_full  = i_rsp_valid && (i_rsp_status == ST_FULL);
    assign rsp_bus   = {i_rsp_x, i_rsp_y, i_rsp_count, i_rsp_status};

    // one request in flight: busy right after an accept
    `PPL_ASSERT_NXT(a_busy_after_req, req_acc, !i_req_ready, "request accepted while busy")

    `PPL_ASSERT_IMP(a_count_bound, i_rsp_valid, i_rsp_count <= CAP_C, "count above capacity")

    `PPL_ASSERT_IMP(a_full_count, rsp_full, i_rsp_count == CAP_C, "list_full with list not full")

    `PPL_ASSERT_IMP(a_err_zero, rsp_err, i_rsp_x == '0 && i_rsp_y == '0, "nonzero point on error")

    `PPL_ASSERT_NXT(a_rsp_hold, rsp_stall, i_rsp_valid && $stable(rsp_bus), "response changed")

endmodule

bind positional_point_list ppl_checker #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .CNT_W      (CNT_W)
) u_ppl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_x      (o_rsp.out_x),
    .i_rsp_y      (o_rsp.out_y),
    .i_rsp_count  (o_rsp.count),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire

@@ tb/tb_positional_point_list.sv @@
// Self-checking testbench for the positional point list: directed corner cases, then random
// grow/shrink request mixes with random stalls on both channels. Depends on ppl_pkg, ppl_if
// and the positional_point_list RTL.
`timescale 1ns / 1ps

module tb_positional_point_list;
    import ppl_pkg::*;

    localparam int CAP      = CAPACITY_DEF;
    localparam int COORD    = COORD_BITS_DEF;
    localparam int CNT_W    = CNT_W_DEF;
    localparam int IDLE_PCT = 37;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;

    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = FN_NEXT + 4'd1;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'hF;

    typedef struct packed {
        logic signed [COORD-1:0] x;
        logic signed [COORD-1:0] y;
    } t_point;

    typedef struct packed {
        t_point             pt;
        logic [CNT_W-1:0]   count;
        logic [STAT_W-1:0]  status;
    } t_rsp;

    typedef enum {MIX_GROW, MIX_BALANCE, MIX_SHRINK} t_mix;

    class point_list_scoreboard;
        t_point store [CAP];
        int     held;
        t_rsp   pending_rsp_q [$];
        int     mismatches;
        int     requests;
        int     responses;
        int     full_hits;
        int     range_hits;
        int     peak_held;

        function new();
            held       = 0;
            mismatches = 0;
            requests   = 0;
            responses  = 0;
            full_hits  = 0;
            range_hits = 0;
            peak_held  = 0;
        endfunction

        function int pending();
            return pending_rsp_q.size();
        endfunction

        task report(input string msg);
            mismatches++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        // update the list copy and queue the response this request must produce
        function void note_request(input logic [FUNC_W-1:0] f, input logic [CNT_W-1:0] p,
                                   input t_point item);
            t_rsp want;
            int   at;
            int   pos;
            int   i;
            want   = '0;
            pos    = int'(p);
            want.status = ST_OK;
            requests++;
            case (f)
                FN_INS_FIRST, FN_INS_LAST, FN_INS_AT: begin
                    if (f == FN_INS_FIRST) at = 0;
                    else if (f == FN_INS_LAST) at = held;
                    else at = pos;
                    if (at > held) begin
                        want.status = ST_RANGE;
                    end else if (held >= CAP) begin
                        want.status = ST_FULL;
                    end else begin
                        for (i = held; i > at; i--) store[i] = store[i-1];
                        store[at] = item;
                        held++;
                    end
                end
                FN_DEL_FIRST, FN_DEL_LAST, FN_DEL_AT: begin
                    if (f == FN_DEL_FIRST) at = 0;
                    else if (f == FN_DEL_LAST) at = held - 1;
                    else at = pos;
                    if (held == 0 || at >= held) begin
                        want.status = ST_RANGE;
                    end else begin
                        want.pt = store[at];
                        for (i = at; i + 1 < held; i++) store[i] = store[i+1];
                        held--;
                    end
                end
                FN_GET, FN_REPLACE: begin
                    if (pos >= held) begin
                        want.status = ST_RANGE;
                    end else begin
                        want.pt = store[pos];
                        if (f == FN_REPLACE) store[pos] = item;
                    end
                end
                FN_NEXT: begin
                    if (pos + 1 >= held) want.status = ST_RANGE;
                    else want.pt = store[pos+1];
                end
                default: want.status = ST_RANGE;
            endcase
            if (want.status == ST_RANGE) range_hits++;
            if (want.status == ST_FULL) full_hits++;
            if (held > peak_held) peak_held = held;
            want.count = CNT_W'(held);
            pending_rsp_q.push_back(want);
        endfunction

        task check_response(input t_rsp got);
            t_rsp want;
            responses++;
            if (pending_rsp_q.size() == 0) begin
                report($sformatf("response %0d with no request outstanding", responses));
                return;
            end
            want = pending_rsp_q.pop_front();
            if (got.pt.x !== want.pt.x)
                report($sformatf("response %0d out_x %0d, want %0d",
                                 responses, got.pt.x, want.pt.x));
            if (got.pt.y !== want.pt.y)
                report($sformatf("response %0d out_y %0d, want %0d",
                                 responses, got.pt.y, want.pt.y));
            if (got.count !== want.count)
                report($sformatf("response %0d count %0d, want %0d",
                                 responses, got.count, want.count));
            if (got.status !== want.status)
                report($sformatf("response %0d status %0d, want %0d",
                                 responses, got.status, want.status));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   stall_cycles;
    point_list_scoreboard sb;

    ppl_req_if #(.CNT_W(CNT_W), .COORD_BITS(COORD)) req_ch ();
    ppl_rsp_if #(.CNT_W(CNT_W), .COORD_BITS(COORD)) rsp_ch ();

    positional_point_list #(
        .CAPACITY   (CAP),
        .COORD_BITS (COORD)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (!idle_on) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // sample both channels mid-cycle; a handshake seen here completes at the next rising edge
    always @(negedge i_clk) begin
        t_rsp   got;
        t_point item;
        if (i_rst_n) begin
            stall_cycles++;
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.pt.x   = rsp_ch.out_x;
                got.pt.y   = rsp_ch.out_y;
                got.count  = rsp_ch.count;
                got.status = rsp_ch.status;
                sb.check_response(got);
                stall_cycles = 0;
            end
            if (req_ch.valid && req_ch.ready) begin
                item.x = req_ch.item_x;
                item.y = req_ch.item_y;
                sb.note_request(req_ch.func, req_ch.position, item);
                stall_cycles = 0;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [FUNC_W-1:0] f, input logic [CNT_W-1:0] p,
                            input logic [COORD-1:0] x, input logic [COORD-1:0] y);
        logic taken;
        if (idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= f;
        req_ch.position <= p;
        req_ch.item_x   <= x;
        req_ch.item_y   <= y;
        do begin
            @(negedge i_clk);
            taken = req_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    function automatic logic [COORD-1:0] rand_coord();
        case ($urandom_range(9))
            0: return {1'b1, {(COORD-1){1'b0}}};
            1: return {1'b0, {(COORD-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return COORD'($urandom);
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] rand_pos(input int held);
        int r;
        r = $urandom_range(99);
        if (r < 75) return CNT_W'($urandom_range(held));
        else if (r < 90) return CNT_W'(held);
        else return CNT_W'($urandom_range(CAP));
    endfunction

    function automatic logic [FUNC_W-1:0] rand_func(input t_mix mix);
        int r;
        int ins_w;
        int del_w;
        case (mix)
            MIX_GROW: begin
                ins_w = 60;
                del_w = 15;
            end
            MIX_SHRINK: begin
                ins_w = 15;
                del_w = 60;
            end
            default: begin
                ins_w = 35;
                del_w = 30;
            end
        endcase
        r = $urandom_range(99);
        if (r < ins_w) begin
            case ($urandom_range(2))
                0: return FN_INS_FIRST;
                1: return FN_INS_LAST;
                default: return FN_INS_AT;
            endcase
        end else if (r < ins_w + del_w) begin
            case ($urandom_range(2))
                0: return FN_DEL_FIRST;
                1: return FN_DEL_LAST;
                default: return FN_DEL_AT;
            endcase
        end else if (r < 98) begin
            case ($urandom_range(2))
                0: return FN_GET;
                1: return FN_REPLACE;
                default: return FN_NEXT;
            endcase
        end
        return FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
    endfunction

    task automatic run_mix(input t_mix mix, input int n);
        int k;
        for (k = 0; k < n; k++)
            send_req(rand_func(mix), rand_pos(sb.held), rand_coord(), rand_coord());
    endtask

    initial begin
        sb               = new();
        idle_on          = 1'b1;
        stall_cycles     = 0;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FN_INS_FIRST;
        req_ch.position  = '0;
        req_ch.item_x    = '0;
        req_ch.item_y    = '0;
        rsp_ch.ready     = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, unknown codes, insert past the end
        send_req(FN_DEL_FIRST, 7'd0, '0, '0);
        send_req(FN_DEL_LAST,  7'd0, '0, '0);
        send_req(FN_DEL_AT,    7'd0, '0, '0);
        send_req(FN_GET,       7'd0, '0, '0);
        send_req(FN_NEXT,      7'd0, '0, '0);
        send_req(FN_UNUSED_LO, 7'd0, 16'h1111, 16'h2222);
        send_req(FN_UNUSED_HI, 7'd64, 16'hFFFF, 16'hFFFF);
        send_req(FN_INS_AT,    7'd1, 16'h0101, 16'h0202);
        // build a four-point list with extreme coordinates
        send_req(FN_INS_FIRST, 7'd0, 16'h7FFF, 16'h8000);
        send_req(FN_INS_LAST,  7'd0, 16'h8000, 16'h7FFF);
        send_req(FN_INS_AT,    7'd1, 16'hFFFF, 16'h0000);
        send_req(FN_INS_AT,    7'd3, 16'h1234, 16'hFFFB);
        send_req(FN_INS_AT,    7'd6, 16'h5555, 16'hAAAA);
        // reads at the edges
        send_req(FN_GET,       7'd0, '0, '0);
        send_req(FN_GET,       7'd3, '0, '0);
        send_req(FN_GET,       7'd4, '0, '0);
        send_req(FN_REPLACE,   7'd2, 16'h0000, 16'hFFFF);
        send_req(FN_REPLACE,   7'd64, 16'h3333, 16'h4444);
        send_req(FN_NEXT,      7'd0, '0, '0);
        send_req(FN_NEXT,      7'd2, '0, '0);
        send_req(FN_NEXT,      7'd3, '0, '0);
        // tear it down
        send_req(FN_DEL_AT,    7'd1, '0, '0);
        send_req(FN_DEL_AT,    7'd3, '0, '0);
        send_req(FN_DEL_LAST,  7'd0, '0, '0);
        send_req(FN_DEL_FIRST, 7'd0, '0, '0);
        send_req(FN_DEL_AT,    7'd0, '0, '0);

        run_mix(MIX_GROW, 250);
        idle_on = 1'b0;
        run_mix(MIX_BALANCE, 200);
        idle_on = 1'b1;
        run_mix(MIX_SHRINK, 250);
        run_mix(MIX_GROW, 300);
        run_mix(MIX_BALANCE, 200);
        run_mix(MIX_SHRINK, 250);
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests and checked %0d responses: %0d range errors,",
                 sb.requests, sb.responses, sb.range_hits);
        $display("%0d inserts into a full list, peak count %0d", sb.full_hits, sb.peak_held);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
